// ----- design/sdws_pkg.sv -----
// Shared types and constants of the spike delay wheel scheduler.
package sdws_pkg;

  localparam int XY_W    = 6;
  localparam int DLY_W   = 8;
  localparam int GW_W    = 7;
  localparam int NIDX_W  = 6;
  localparam int LIN_W   = 13;
  localparam int WGT_W   = 16;
  localparam int SID_W   = 16;
  localparam int GIDX_W  = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_GROUP_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRE_DIRECT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYN_WEIGHT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_ID    = 2'd3;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_TICK   = 1'b1;

  localparam logic [GW_W-1:0] GROUP_WIDTH_RST = 7'd8;

  typedef struct packed {
    logic             mode;
    logic [XY_W-1:0]  x_pos;
    logic [XY_W-1:0]  y_pos;
    logic [DLY_W-1:0] delay;
  } sdws_in_t;

  typedef struct packed {
    logic [NIDX_W-1:0]       neuron_index;
    logic [GIDX_W-1:0]       global_index;
    logic                    direct_fire;
    logic signed [WGT_W-1:0] weight;
    logic                    last;
  } sdws_out_t;

endpackage

// ----- design/spike_delay_wheel_scheduler.sv -----
// Top level of the spike delay wheel scheduler: slot memory, control and result register.
//
// The block keeps a timing wheel of DELAY_SLOTS slots, each a bitmap of NEURONS neurons,
// in one synchronous memory with a registered read. For an insert item the slot is read
// in the cycle it is accepted and, if the neuron lies in the group, written back with its
// bit set in the next, so the input is stalled during the write back. A tick item reads
// the current slot and then yields one result per set neuron bit, in ascending index
// order, as fast as the result side takes them; an empty slot ends after the read with no
// result. The output register lets a new item be accepted while the final result still
// waits. Every slot has a valid bit that reset clears, so the block needs no clearing pass
// and is ready as soon as reset is released.
module spike_delay_wheel_scheduler
  import sdws_pkg::*;
#(
  parameter int DELAY_SLOTS = 16,
  parameter int NEURONS     = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sdws_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sdws_out_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SW = $clog2(DELAY_SLOTS);

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_INS_WR  = 2'd1;
  localparam logic [1:0] ST_TICK_LD = 2'd2;
  localparam logic [1:0] ST_DRAIN   = 2'd3;

  typedef logic [(2**DLY_W)-1:0][SW-1:0] dmod_tab_t;

  function automatic dmod_tab_t build_dmod();
    dmod_tab_t t;
    for (int i = 0; i < 2**DLY_W; i++) begin
      t[i] = SW'(i % DELAY_SLOTS);
    end
    return t;
  endfunction

  // Delay reduced modulo the slot count, built at elaboration.
  localparam dmod_tab_t DMOD_TAB = build_dmod();

  // Configuration registers.
  logic [GW_W-1:0]         group_width_r;
  logic                    fire_direct_r;
  logic signed [WGT_W-1:0] syn_weight_r;
  logic [SID_W-1:0]        start_id_r;

  // Control state.
  logic [1:0]             state_r, state_nxt;
  logic [SW-1:0]          cur_r, cur_nxt;
  logic [DELAY_SLOTS-1:0] slot_vld_r, slot_vld_nxt;
  logic [NEURONS-1:0]     pending_r, pending_nxt;
  logic                   out_valid_r, out_valid_nxt;

  // Insert bookkeeping and result payload.
  logic [SW-1:0]     slot_r;
  logic [NIDX_W-1:0] idx_r;
  logic              hit_r;
  sdws_out_t         out_data_r;

  // Slot memory.
  logic [NEURONS-1:0] wheel_mem [DELAY_SLOTS];
  logic [NEURONS-1:0] rd_data_r;
  logic [SW-1:0]      rd_addr;
  logic               mem_we;
  logic [NEURONS-1:0] wr_data;

  logic               in_acc;
  logic [LIN_W-1:0]   lin_idx;
  logic [SW:0]        slot_sum;
  logic [SW-1:0]      slot_calc;
  logic               out_free;
  logic [NEURONS-1:0] low_bit;
  logic [NEURONS-1:0] rest_bits;
  logic [NIDX_W-1:0]  low_idx;
  logic [NEURONS-1:0] loaded_bits;
  sdws_out_t          result;
  logic               load_out;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign lin_idx = LIN_W'(in_data.x_pos) + LIN_W'(in_data.y_pos) * LIN_W'(group_width_r);

  // The current slot is below the slot count, so one subtract brings the sum back in range.
  assign slot_sum  = {1'b0, cur_r} + {1'b0, DMOD_TAB[in_data.delay]};
  assign slot_calc = (slot_sum >= (SW+1)'(DELAY_SLOTS)) ?
                     SW'(slot_sum - (SW+1)'(DELAY_SLOTS)) : SW'(slot_sum);

  assign rd_addr = (in_data.mode == MODE_TICK) ? cur_r : slot_calc;

  // A slot whose valid bit is clear reads as empty.
  assign loaded_bits = slot_vld_r[cur_r] ? rd_data_r : '0;
  assign mem_we      = (state_r == ST_INS_WR) && hit_r;
  assign wr_data     = (slot_vld_r[slot_r] ? rd_data_r : '0) | (NEURONS'(1) << idx_r);

  // Lowest pending neuron first.
  assign low_bit   = pending_r & (~pending_r + NEURONS'(1));
  assign rest_bits = pending_r & ~low_bit;

  always_comb begin
    low_idx = '0;
    for (int i = 0; i < NEURONS; i++) begin
      if (low_bit[i]) begin
        low_idx = low_idx | NIDX_W'(i);
      end
    end
  end

  always_comb begin
    result.neuron_index = low_idx;
    result.global_index = GIDX_W'(low_idx) + GIDX_W'(start_id_r);
    result.direct_fire  = fire_direct_r;
    result.weight       = fire_direct_r ? '0 : syn_weight_r;
    result.last         = (rest_bits == '0);
  end

  assign load_out = (state_r == ST_DRAIN) && out_free;

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    slot_vld_nxt  = slot_vld_r;
    pending_nxt   = pending_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_data.mode == MODE_TICK) ? ST_TICK_LD : ST_INS_WR;
        end
      end
      ST_INS_WR: begin
        if (hit_r) begin
          slot_vld_nxt[slot_r] = 1'b1;
        end
        state_nxt = ST_IDLE;
      end
      ST_TICK_LD: begin
        pending_nxt         = loaded_bits;
        slot_vld_nxt[cur_r] = 1'b0;
        cur_nxt             = (cur_r == SW'(DELAY_SLOTS - 1)) ? '0 : cur_r + SW'(1);
        state_nxt           = (loaded_bits == '0) ? ST_IDLE : ST_DRAIN;
      end
      ST_DRAIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          pending_nxt   = rest_bits;
          if (rest_bits == '0) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_r       <= '0;
      slot_vld_r  <= '0;
      pending_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      slot_vld_r  <= slot_vld_nxt;
      pending_r   <= pending_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_width_r <= GROUP_WIDTH_RST;
      fire_direct_r <= 1'b0;
      syn_weight_r  <= '0;
      start_id_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GROUP_WIDTH: group_width_r <= cfg_data[GW_W-1:0];
        CFG_FIRE_DIRECT: fire_direct_r <= cfg_data[0];
        CFG_SYN_WEIGHT:  syn_weight_r  <= cfg_data[WGT_W-1:0];
        CFG_START_ID:    start_id_r    <= cfg_data[SID_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      slot_r <= slot_calc;
      idx_r  <= lin_idx[NIDX_W-1:0];
      hit_r  <= (lin_idx < LIN_W'(NEURONS));
    end
    if (load_out) begin
      out_data_r <= result;
    end
  end

  // The read issued with an accepted item is consumed the next cycle; the input stalls
  // during the write back, so a later read always sees the updated slot.
  always_ff @(posedge clk) begin
    rd_data_r <= wheel_mem[rd_addr];
    if (mem_we) begin
      wheel_mem[slot_r] <= wr_data;
    end
  end

  a_out_from_drain: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DRAIN)
    else $error("result appeared outside of a drain");

  a_drain_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DRAIN |-> pending_r != '0)
    else $error("drain with no pending neuron");

  a_tick_clears_slot: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_TICK_LD |=> !slot_vld_r[$past(cur_r)])
    else $error("drained slot still marked valid");

  a_insert_marks_slot: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_INS_WR && hit_r |=> slot_vld_r[$past(slot_r)])
    else $error("written slot not marked valid");

  a_last_ends_drain: assert property (@(posedge clk) disable iff (!rst_n)
    load_out && rest_bits == '0 |=> state_r == ST_IDLE && out_data_r.last && out_valid_r)
    else $error("final result of a tick not marked last");

endmodule

// ----- verif/spike_delay_wheel_scheduler_checker.sv -----
`timescale 1ns / 100ps
// Checker for the spike delay wheel scheduler: tracks the wheel and compares drained spikes.
module spike_delay_wheel_scheduler_checker
  import sdws_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  sdws_in_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  sdws_out_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    spikes_owed
);

  localparam int WHEEL_SLOTS = 16;
  localparam int GROUP_SIZE  = 64;

  logic [63:0]      wheel_bits [WHEEL_SLOTS];
  logic [3:0]       wheel_pos;
  logic [GW_W-1:0]  row_width;
  logic             fire_now;
  logic [WGT_W-1:0] inj_weight;
  logic [SID_W-1:0] id_base;
  sdws_out_t        spikes_due [$];
  int               errors = 0;

  assign fail_count = errors;

  task automatic clear_wheel();
    for (int s = 0; s < WHEEL_SLOTS; s++) begin
      wheel_bits[s] = '0;
    end
    wheel_pos  = '0;
    row_width  = GROUP_WIDTH_RST;
    fire_now   = 1'b0;
    inj_weight = '0;
    id_base    = '0;
    spikes_due.delete();
  endtask

  task automatic schedule_spike(sdws_in_t ev);
    int lin;
    int slot;
    lin = int'(ev.x_pos) + int'(ev.y_pos) * int'(row_width);
    // Neurons outside the group are silently dropped.
    if (lin < GROUP_SIZE) begin
      slot = (int'(wheel_pos) + int'(ev.delay)) % WHEEL_SLOTS;
      wheel_bits[slot][lin] = 1'b1;
    end
  endtask

  task automatic drain_slot();
    sdws_out_t held;
    bit        have;
    have = 1'b0;
    held = '0;
    for (int i = 0; i < GROUP_SIZE; i++) begin
      if (wheel_bits[wheel_pos][i]) begin
        if (have) spikes_due.push_back(held);
        held.neuron_index = NIDX_W'(i);
        held.global_index = GIDX_W'(i) + GIDX_W'(id_base);
        held.direct_fire  = fire_now;
        held.weight       = fire_now ? '0 : inj_weight;
        held.last         = 1'b0;
        have = 1'b1;
      end
    end
    // The final spike of a tick carries the last flag.
    if (have) begin
      held.last = 1'b1;
      spikes_due.push_back(held);
    end
    wheel_bits[wheel_pos] = '0;
    wheel_pos = wheel_pos + 4'd1;
  endtask

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  task automatic check_spike(sdws_out_t got);
    sdws_out_t want;
    if (spikes_due.size() == 0) begin
      $error("unexpected result item: neuron_index %0d", got.neuron_index);
      errors++;
      return;
    end
    want = spikes_due.pop_front();
    compare_field("neuron_index", 32'(want.neuron_index), 32'(got.neuron_index));
    compare_field("global_index", 32'(want.global_index), 32'(got.global_index));
    compare_field("direct_fire", 32'(want.direct_fire), 32'(got.direct_fire));
    compare_field("weight", 32'(want.weight), 32'(got.weight));
    compare_field("last", 32'(want.last), 32'(got.last));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_wheel();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_GROUP_WIDTH: row_width  = cfg_data[GW_W-1:0];
          CFG_FIRE_DIRECT: fire_now   = cfg_data[0];
          CFG_SYN_WEIGHT:  inj_weight = cfg_data[WGT_W-1:0];
          CFG_START_ID:    id_base    = cfg_data[SID_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (in_data.mode == MODE_TICK) drain_slot();
        else schedule_spike(in_data);
      end
      if (out_valid && !out_stall) check_spike(out_data);
    end
    spikes_owed <= spikes_due.size();
  end

endmodule

// ----- verif/spike_delay_wheel_scheduler_test.sv -----
`timescale 1ns / 100ps
// Testbench top for the spike delay wheel scheduler: clock, reset, stimulus, stalls and verdict.
module spike_delay_wheel_scheduler_test;
  import sdws_pkg::*;

  localparam int IDLE_LIMIT = 4000;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  sdws_in_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  sdws_out_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int fail_count;
  int spikes_owed;
  int tx_max      = 0;
  int rx_max      = 0;
  int hold_len    = 0;
  int idle_cycles = 0;

  always #6 clk = ~clk;

  spike_delay_wheel_scheduler dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  spike_delay_wheel_scheduler_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .spikes_owed(spikes_owed)
  );

  // Ends the run when nothing moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("FAIL spike_delay_wheel_scheduler");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: a random wait before each item, or a long hold-off when requested.
  initial begin
    int n;
    forever begin
      if (hold_len > 0) begin
        n = hold_len;
        hold_len = 0;
      end else begin
        n = $urandom_range(0, rx_max);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid && hold_len == 0) @(posedge clk);
    end
  end

  function automatic sdws_in_t insert_event(int x, int y, int d);
    sdws_in_t ev;
    ev.mode  = MODE_INSERT;
    ev.x_pos = XY_W'(x);
    ev.y_pos = XY_W'(y);
    ev.delay = DLY_W'(d);
    return ev;
  endfunction

  // Tick fields other than mode are ignored, so they carry random bits.
  function automatic sdws_in_t tick_event();
    sdws_in_t ev;
    ev.mode  = MODE_TICK;
    ev.x_pos = XY_W'($urandom);
    ev.y_pos = XY_W'($urandom);
    ev.delay = DLY_W'($urandom);
    return ev;
  endfunction

  // Most inserts hit a neuron inside the group; about one in ten uses raw coordinates.
  function automatic sdws_in_t random_event(logic [GW_W-1:0] gw);
    sdws_in_t ev;
    int       idx;
    if ($urandom_range(0, 99) < 22) return tick_event();
    ev = insert_event($urandom, $urandom, $urandom);
    if ($urandom_range(0, 9) != 0) begin
      idx = $urandom_range(0, 63);
      if (gw == 0) begin
        ev.x_pos = XY_W'(idx);
      end else if (gw > 63) begin
        ev.x_pos = XY_W'(idx);
        ev.y_pos = '0;
      end else begin
        ev.x_pos = XY_W'(idx % gw);
        ev.y_pos = XY_W'(idx / gw);
      end
    end
    return ev;
  endfunction

  task automatic send_item(sdws_in_t ev);
    int gap;
    gap = $urandom_range(0, tx_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    do @(posedge clk); while (in_stall);
  endtask

  // Waits until every predicted spike has come out, plus the tail of a last insert.
  task automatic wait_idle(int tail);
    in_valid <= 1'b0;
    @(posedge clk);
    while (spikes_owed != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic program_regs(logic [GW_W-1:0] gw, logic fd, logic [15:0] wt, logic [15:0] sid);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_GROUP_WIDTH;
    cfg_data  <= CFG_DATA_W'(gw);
    @(posedge clk);
    cfg_index <= CFG_FIRE_DIRECT;
    cfg_data  <= CFG_DATA_W'(fd);
    @(posedge clk);
    cfg_index <= CFG_SYN_WEIGHT;
    cfg_data  <= wt;
    @(posedge clk);
    cfg_index <= CFG_START_ID;
    cfg_data  <= sid;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_phase(logic [GW_W-1:0] gw, logic fd, logic [15:0] wt, logic [15:0] sid,
                           int tx, int rx, int count);
    program_regs(gw, fd, wt, sid);
    tx_max = tx;
    rx_max = rx;
    repeat (count) send_item(random_event(gw));
    wait_idle(6);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset register values: row width 8, weight mode, zero weight and offset.
    send_item(insert_event(0, 0, 0));
    send_item(insert_event(7, 7, 0));
    send_item(insert_event(0, 0, 16));
    send_item(insert_event(63, 63, 0));
    send_item(insert_event(0, 8, 3));
    send_item(insert_event(5, 2, 255));
    send_item(insert_event(3, 1, 1));
    send_item(insert_event(1, 0, 1));
    send_item(tick_event());
    send_item(tick_event());
    send_item(tick_event());
    send_item(insert_event(2, 3, 0));
    send_item(tick_event());
    send_item(insert_event(63, 0, 128));
    send_item(insert_event(0, 63, 0));
    send_item(tick_event());
    wait_idle(6);

    run_phase(7'd1, 1'b1, 16'h7FFF, 16'hFFFF, 0, 0, 45);
    run_phase(7'd64, 1'b0, 16'h8000, 16'h0000, 19, 19, 45);
    run_phase(7'd0, 1'b0, 16'hFFFF, 16'h8000, 19, 0, 45);
    run_phase(7'd127, 1'b1, 16'($urandom), 16'($urandom), 0, 19, 40);
    run_phase(7'($urandom_range(1, 64)), 1'b0, 16'($urandom), 16'($urandom), 19, 19, 45);
    run_phase(7'($urandom_range(2, 63)), 1'($urandom), 16'($urandom), 16'($urandom), 5, 5, 40);

    // Fill the current slot with every neuron while the result side holds off,
    // so the drain backs up into the input.
    program_regs(7'd8, 1'b0, 16'h0100, 16'd100);
    tx_max   = 0;
    rx_max   = 3;
    hold_len = 300;
    for (int i = 0; i < 64; i++) begin
      send_item(insert_event(i % 8, i / 8, 16 * $urandom_range(0, 15)));
    end
    send_item(tick_event());
    send_item(tick_event());
    repeat (12) send_item(random_event(7'd8));
    wait_idle(20);

    if (fail_count == 0 && spikes_owed == 0) begin
      $display("PASS spike_delay_wheel_scheduler");
    end else begin
      $display("FAIL spike_delay_wheel_scheduler");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/sdws_pkg.sv
design/spike_delay_wheel_scheduler.sv
verif/spike_delay_wheel_scheduler_checker.sv
verif/spike_delay_wheel_scheduler_test.sv
